FILE: design/euler_to_quaternion_core_assert.svh
// Assertion macros for the euler_to_quaternion_core design files; etq_fifo uses them.
`ifndef EULER_TO_QUATERNION_CORE_ASSERT_SVH
`define EULER_TO_QUATERNION_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define ETQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define ETQ_NEVER(label, cond, msg) \
  `ETQ_ASSERT(label, !(cond), msg)

`endif

FILE: design/etq_pkg.sv
// Types, constants and arithmetic helpers for the Euler angle to quaternion core.
`timescale 1ns / 1ps
package etq_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int WORK_BITS  = 30;
  localparam int OUT_BITS   = FRAC_BITS + 2;

  // half angle, its square, series accumulator, intermediate quotient, signed trig value
  localparam int XW   = WORK_BITS + 1;
  localparam int X2W  = WORK_BITS + 2;
  localparam int ACCW = WORK_BITS + 1;
  localparam int VW   = WORK_BITS + 2;
  localparam int TW   = WORK_BITS + 2;
  localparam int PW   = 64;

  // pi in Q2.30
  localparam logic [31:0] PI_WORK = 32'd3373259426;
  localparam logic [ACCW-1:0] WORK_ONE = {1'b1, {WORK_BITS{1'b0}}};

  // series pipeline and back end depth
  localparam int STEPS    = 8;
  localparam int SC_LAT   = 3 * STEPS + 1;
  localparam int BACK_LAT = SC_LAT + 3;
  localparam int NUM_TRI  = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // series denominators and their reciprocals floor(2^32 / k); zero marks a bypassed step
  localparam int DEN_W = 8;
  localparam int RCP_W = 32;
  localparam logic [DEN_W-1:0] SIN_DEN [STEPS] = '{
    8'd0, 8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [RCP_W-1:0] SIN_RCP [STEPS] = '{
    32'd0, 32'd20452225, 32'd27531841, 32'd39045157,
    32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
  };
  localparam logic [DEN_W-1:0] COS_DEN [STEPS] = '{
    8'd240, 8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [RCP_W-1:0] COS_RCP [STEPS] = '{
    32'd17895697, 32'd23598721, 32'd32537631, 32'd47721858,
    32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
  } etq_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
    logic signed [OUT_BITS-1:0] quat_w;
  } etq_out_t;

  // one classified half angle
  typedef struct packed {
    logic           neg;
    logic [XW-1:0]  x;
    logic [X2W-1:0] x2;
  } etq_half_t;

  typedef struct packed {
    etq_half_t [2:0] ang;
  } etq_item_t;

  // series lane state between steps
  typedef struct packed {
    logic            neg;
    logic [XW-1:0]   x;
    logic [X2W-1:0]  x2;
    logic [ACCW-1:0] sacc;
    logic [ACCW-1:0] cacc;
  } etq_lane_t;

  // lane state inside one series step
  typedef struct packed {
    etq_lane_t     lane;
    logic [VW-1:0] vs;
    logic [VW-1:0] vc;
    logic [VW-1:0] qs;
    logic [VW-1:0] qc;
  } etq_mid_t;

  // divide by 2^sh, rounding half away from zero
  function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                     input int unsigned sh);
    logic [PW-1:0] mag;
    logic [PW-1:0] half;
    logic [PW-1:0] res;
    mag  = v[PW-1] ? PW'(-v) : PW'(v);
    half = PW'(1) << (sh - 1);
    res  = (mag + half) >> sh;
    return v[PW-1] ? -$signed(res) : $signed(res);
  endfunction

  // clamp to plus or minus one in Q1.FRAC_BITS
  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] lim;
    lim = PW'(1) <<< FRAC_BITS;
    if (v > lim) return OUT_BITS'(lim);
    if (v < -lim) return OUT_BITS'(-lim);
    return OUT_BITS'(v);
  endfunction

endpackage

FILE: design/etq_front.sv
// Front end: accepts angle transfers and forms half angles and their squares.
`timescale 1ns / 1ps
module etq_front import etq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  etq_in_t   in_data_i,
  input  logic      full_i,
  output logic      push_o,
  output etq_item_t push_data_o
);

  logic                         f1_vld_q, f2_vld_q;
  logic                         front_en;
  logic signed [ANGLE_BITS-1:0] ang [3];
  logic [2:0]                   neg_d, f1_neg_q;
  logic [XW-1:0]                x_d [3];
  logic [XW-1:0]                f1_x_q [3];
  etq_item_t                    f2_d, f2_q;

  // advance while the last stage is empty or the queue has room
  assign front_en   = !f2_vld_q || !full_i;
  assign in_ready_o = front_en;
  assign push_o     = f2_vld_q && !full_i;
  assign push_data_o = f2_q;

  assign ang[0] = in_data_i.angle_x;
  assign ang[1] = in_data_i.angle_y;
  assign ang[2] = in_data_i.angle_z;

  // split sign and scale the magnitude to a Q30 half angle
  always_comb begin
    logic [ANGLE_BITS-1:0]    mag;
    logic [ANGLE_BITS+32:0]   prod;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = ang[i][ANGLE_BITS-1];
      mag      = neg_d[i] ? ANGLE_BITS'(-ang[i]) : ANGLE_BITS'(ang[i]);
      prod     = (ANGLE_BITS+33)'(mag) * (ANGLE_BITS+33)'(PI_WORK)
                 + ((ANGLE_BITS+33)'(1) << (ANGLE_BITS - 1));
      x_d[i]   = prod[ANGLE_BITS +: XW];
    end
  end

  // square each half angle
  always_comb begin
    logic [2*XW-1:0] sq;
    for (int i = 0; i < 3; i++) begin
      sq                = f1_x_q[i] * f1_x_q[i];
      f2_d.ang[i].neg   = f1_neg_q[i];
      f2_d.ang[i].x     = f1_x_q[i];
      f2_d.ang[i].x2    = sq[WORK_BITS +: X2W];
    end
  end

  // hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (front_en) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (front_en) begin
      f1_neg_q <= neg_d;
      f1_x_q   <= x_d;
      f2_q     <= f2_d;
    end
  end

endmodule

FILE: design/etq_fifo.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`include "euler_to_quaternion_core_assert.svh"
module etq_fifo import etq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  etq_item_t push_data_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output etq_item_t head_o
);

  etq_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `ETQ_NEVER(a_no_overflow, push_i && full_o, "queue push while full")
  `ETQ_NEVER(a_no_underflow, pop_i && empty_o, "queue pop while empty")
  `ETQ_ASSERT(a_count_up, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "queue count did not rise")

endmodule

FILE: design/etq_sincos.sv
// Pipelined sine and cosine of one half angle by truncated series.
`timescale 1ns / 1ps
module etq_sincos import etq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  etq_half_t            half_i,
  output logic signed [TW-1:0] sin_o,
  output logic signed [TW-1:0] cos_o
);

  etq_lane_t            lane_in;
  etq_lane_t            lane_q [STEPS];
  logic signed [TW-1:0] sin_d, cos_d, sin_q, cos_q;

  // start both series at one
  always_comb begin
    lane_in.neg  = half_i.neg;
    lane_in.x    = half_i.x;
    lane_in.x2   = half_i.x2;
    lane_in.sacc = WORK_ONE;
    lane_in.cacc = WORK_ONE;
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    etq_lane_t src, c_d;
    etq_mid_t  a_d, a_q, b_d, b_q;

    if (j == 0) begin : g_first
      assign src = lane_in;
    end else begin : g_next
      assign src = lane_q[j-1];
    end

    // multiply the square by each accumulator
    always_comb begin
      logic [X2W+ACCW-1:0] ps, pc;
      ps       = src.x2 * src.sacc;
      pc       = src.x2 * src.cacc;
      a_d.lane = src;
      a_d.vs   = ps[WORK_BITS +: VW];
      a_d.vc   = pc[WORK_BITS +: VW];
      a_d.qs   = '0;
      a_d.qc   = '0;
    end

    // estimate the quotients by reciprocal
    always_comb begin
      logic [VW+RCP_W-1:0] ms, mc;
      ms     = a_q.vs * SIN_RCP[j];
      mc     = a_q.vc * COS_RCP[j];
      b_d    = a_q;
      b_d.qs = ms[RCP_W +: VW];
      b_d.qc = mc[RCP_W +: VW];
    end

    // correct the quotients and step the accumulators
    always_comb begin
      logic [VW+DEN_W-1:0] rs, rc;
      logic [VW-1:0]       ts, tc;
      rs  = (VW+DEN_W)'(b_q.vs) - (VW+DEN_W)'(b_q.qs) * SIN_DEN[j];
      rc  = (VW+DEN_W)'(b_q.vc) - (VW+DEN_W)'(b_q.qc) * COS_DEN[j];
      ts  = b_q.qs + VW'(rs >= (VW+DEN_W)'(SIN_DEN[j]));
      tc  = b_q.qc + VW'(rc >= (VW+DEN_W)'(COS_DEN[j]));
      c_d = b_q.lane;
      if (SIN_DEN[j] != '0) begin
        c_d.sacc = (ts >= VW'(WORK_ONE)) ? '0 : ACCW'(VW'(WORK_ONE) - ts);
      end
      c_d.cacc = (tc >= VW'(WORK_ONE)) ? '0 : ACCW'(VW'(WORK_ONE) - tc);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q       <= a_d;
        b_q       <= b_d;
        lane_q[j] <= c_d;
      end
    end
  end

  // scale sine by the angle, cap at one and restore the sign
  always_comb begin
    logic [XW+ACCW-1:0] sp;
    logic [ACCW-1:0]    sv;
    sp    = lane_q[STEPS-1].x * lane_q[STEPS-1].sacc;
    sv    = sp[WORK_BITS +: ACCW];
    if (sv > WORK_ONE) sv = WORK_ONE;
    sin_d = lane_q[STEPS-1].neg ? -$signed(TW'(sv)) : $signed(TW'(sv));
    cos_d = $signed(TW'(lane_q[STEPS-1].cacc));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

FILE: design/etq_back.sv
// Back end: series lanes, triple products, rounding and the output register.
`timescale 1ns / 1ps
module etq_back import etq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  etq_item_t head_i,
  input  logic      empty_i,
  output logic      pop_o,
  input  logic      rot_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output etq_out_t  out_data_o
);

  logic                 en;
  logic [BACK_LAT-1:0]  vld_q;
  logic signed [TW-1:0] s [3];
  logic signed [TW-1:0] c [3];
  logic signed [TW-1:0] p [NUM_TRI];
  logic signed [TW-1:0] q [NUM_TRI];
  logic signed [TW-1:0] r [NUM_TRI];
  logic signed [TW-1:0] pq_d [NUM_TRI];
  logic signed [TW-1:0] pq_q [NUM_TRI];
  logic signed [TW-1:0] r_q [NUM_TRI];
  logic signed [PW-1:0] tp_q [NUM_TRI];
  etq_out_t             out_d, out_q;

  // advance the whole pipeline unless a result is stalled at the output
  assign en          = !vld_q[BACK_LAT-1] || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vld_q[BACK_LAT-1];
  assign out_data_o  = out_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    etq_sincos u_sincos (
      .clk_i  (clk_i),
      .en_i   (en),
      .half_i (head_i.ang[i]),
      .sin_o  (s[i]),
      .cos_o  (c[i])
    );
  end

  // operands of the eight triple products
  always_comb begin
    p[0] = s[0]; q[0] = c[1]; r[0] = c[2];
    p[1] = s[1]; q[1] = s[2]; r[1] = c[0];
    p[2] = s[1]; q[2] = c[0]; r[2] = c[2];
    p[3] = s[0]; q[3] = s[2]; r[3] = c[1];
    p[4] = s[2]; q[4] = c[0]; r[4] = c[1];
    p[5] = s[0]; q[5] = s[1]; r[5] = c[2];
    p[6] = c[0]; q[6] = c[1]; r[6] = c[2];
    p[7] = s[1]; q[7] = s[2]; r[7] = s[0];
  end

  // first product, rounded back to Q30
  always_comb begin
    logic signed [PW-1:0] m;
    for (int i = 0; i < NUM_TRI; i++) begin
      m       = PW'(p[i]) * PW'(q[i]);
      pq_d[i] = TW'(rnd_shift(m, WORK_BITS));
    end
  end

  // combine pairs, with the signs of x and y set by the rotation order, round and saturate
  always_comb begin
    logic signed [PW-1:0] sx, sy, sz, sw;
    sx = rot_i ? (tp_q[0] + tp_q[1]) : (tp_q[0] - tp_q[1]);
    sy = rot_i ? (tp_q[2] - tp_q[3]) : (tp_q[2] + tp_q[3]);
    sz = tp_q[4] - tp_q[5];
    sw = tp_q[6] + tp_q[7];
    out_d.quat_x = sat_out(rnd_shift(sx, 2 * WORK_BITS - FRAC_BITS));
    out_d.quat_y = sat_out(rnd_shift(sy, 2 * WORK_BITS - FRAC_BITS));
    out_d.quat_z = sat_out(rnd_shift(sz, 2 * WORK_BITS - FRAC_BITS));
    out_d.quat_w = sat_out(rnd_shift(sw, 2 * WORK_BITS - FRAC_BITS));
  end

  // shift valid flags along with the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_LAT-2:0], !empty_i};
    end
  end

  // product stages and output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_TRI; i++) begin
        pq_q[i] <= pq_d[i];
        r_q[i]  <= r[i];
        tp_q[i] <= PW'(pq_q[i]) * PW'(r_q[i]);
      end
      out_q <= out_d;
    end
  end

endmodule

FILE: design/euler_to_quaternion_core.sv
// Top level of the Euler angle to quaternion core.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries three signed binary angles
//   (full range spans minus pi to pi). Output channel out_valid_o/out_ready_i
//   carries the quaternion x, y, z, w as signed Q1.14, saturated to one.
//   The cfg channel writes the rotation order bit (0 XYZ, 1 ZXY); it is
//   always ready and should only be written while the core is empty.
// Pipeline: an input transfer passes the input register and the second front
//   stage, the queue, 25 series stages (eight series steps of three stages
//   each plus the sine scaling) and three product stages.
// Throughput: one transfer per cycle while the output is not stalled, set by
//   the fully pipelined series and product stages; the queue lets the front
//   keep taking transfers while the output is stalled, until it is full.
// Reset: clears all valid flags, the queue and the rotation order to XYZ.
// When the receiver stalls, the back end freezes with its result held; the
//   front fills the four-entry queue and then drops in_ready_o.
`timescale 1ns / 1ps
module euler_to_quaternion_core import etq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  etq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output etq_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i
);

  logic      rot_q;
  logic      push, pop, full, empty;
  etq_item_t push_data, head;

  // rotation order register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= 1'b0;
    end else if (cfg_valid_i) begin
      rot_q <= cfg_data_i;
    end
  end

  etq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  etq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  etq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .rot_i       (rot_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
